// ----- sv/gsp_pkg.sv -----
package gsp_pkg;

    localparam int NUM_PAD_PORTS = 4;
    localparam int OP_W = 2;
    localparam int PADS_W = 3;
    localparam int CTRL_W = 14;
    localparam int WORD_W = 15;
    localparam int SHIFT_W = 64;
    localparam int BITS_W = 6;
    localparam int COUNT_W = 10;
    localparam int TRIG_W = 14;
    localparam int REG_IDX_W = 3;

    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_START_DELAY = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HALF_PERIOD = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_TAIL_DELAY = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TRIGGER_SPAN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ID_WINDOW_LOW = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ID_WINDOW_HIGH = 3'd5;

    localparam logic [SHIFT_W-1:0] ID_WORD =
        64'h2400 | (64'h1830 << 15) | (64'h19b0 << 30);
    localparam logic [BITS_W-1:0] ID_BITS = 6'd49;
    localparam logic [SHIFT_W-1:0] LEAD_NARROW = 64'h1;
    localparam logic [SHIFT_W-1:0] LEAD_WIDE = 64'h7;
    localparam logic [BITS_W-1:0] BITS_NARROW = 6'd15;
    localparam logic [BITS_W-1:0] BITS_WIDE = 6'd5;

    localparam logic [7:0] PORT_IDLE = 8'hf0;
    localparam logic [7:0] PORT_NO_PAD = 8'hff;
    localparam logic [7:0] PORT_NARROW_HIGH = 8'hc0;

    typedef struct packed {
        logic [7:0] start_delay;
        logic [7:0] half_period;
        logic [9:0] tail_delay;
        logic [TRIG_W-1:0] trigger_span;
        logic [TRIG_W-1:0] id_window_low;
        logic [TRIG_W-1:0] id_window_high;
    } cfg_t;

    typedef logic [NUM_PAD_PORTS-1:0][CTRL_W-1:0] pad_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [PADS_W-1:0] pads;
        pad_ctrl_t controls;
    } item_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift_word;
        logic [BITS_W-1:0] bits_left;
    } packet_t;

    typedef struct packed {
        logic [7:0] port_byte;
        logic busy;
    } result_t;

endpackage

// ----- sv/gsp_cfg_regs.sv -----
module gsp_cfg_regs (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    output gsp_pkg::cfg_t cfg
);

    gsp_pkg::cfg_t cfg_reg;
    gsp_pkg::cfg_t cfg_next;
    logic [gsp_pkg::REG_IDX_W-1:0] index;
    logic wr_en;

    assign index = paddr[4:2];
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                gsp_pkg::REG_START_DELAY:    cfg_next.start_delay = pwdata[7:0];
                gsp_pkg::REG_HALF_PERIOD:    cfg_next.half_period = pwdata[7:0];
                gsp_pkg::REG_TAIL_DELAY:     cfg_next.tail_delay = pwdata[9:0];
                gsp_pkg::REG_TRIGGER_SPAN:   cfg_next.trigger_span = pwdata[13:0];
                gsp_pkg::REG_ID_WINDOW_LOW:  cfg_next.id_window_low = pwdata[13:0];
                gsp_pkg::REG_ID_WINDOW_HIGH: cfg_next.id_window_high = pwdata[13:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            gsp_pkg::REG_START_DELAY:    prdata = {24'd0, cfg_reg.start_delay};
            gsp_pkg::REG_HALF_PERIOD:    prdata = {24'd0, cfg_reg.half_period};
            gsp_pkg::REG_TAIL_DELAY:     prdata = {22'd0, cfg_reg.tail_delay};
            gsp_pkg::REG_TRIGGER_SPAN:   prdata = {18'd0, cfg_reg.trigger_span};
            gsp_pkg::REG_ID_WINDOW_LOW:  prdata = {18'd0, cfg_reg.id_window_low};
            gsp_pkg::REG_ID_WINDOW_HIGH: prdata = {18'd0, cfg_reg.id_window_high};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_delay <= 8'd40;
            cfg_reg.half_period <= 8'd5;
            cfg_reg.tail_delay <= 10'd160;
            cfg_reg.trigger_span <= 14'd10000;
            cfg_reg.id_window_low <= 14'd9900;
            cfg_reg.id_window_high <= 14'd9940;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- sv/gsp_packet_builder.sv -----
module gsp_packet_builder #(
    parameter int MAX_PADS = 4
) (
    input  gsp_pkg::pad_ctrl_t controls,
    input  logic [gsp_pkg::PADS_W-1:0] pads,
    input  logic wide,
    output gsp_pkg::packet_t packet
);

    always_comb
    begin
        logic [gsp_pkg::SHIFT_W-1:0] word;
        packet.shift_word = wide ? gsp_pkg::LEAD_WIDE : gsp_pkg::LEAD_NARROW;
        packet.bits_left = 6'd1;
        for (int js = 0; js < MAX_PADS; js++)
        begin
            word = '0;
            word[gsp_pkg::CTRL_W-1:0] = ~controls[js];
            word[gsp_pkg::WORD_W-1] = ^word[gsp_pkg::CTRL_W-1:0];
            if (pads > js[gsp_pkg::PADS_W-1:0])
            begin
                if (wide)
                begin
                    packet.shift_word = packet.shift_word | (word << (js * 15 + 3));
                    packet.bits_left = packet.bits_left + gsp_pkg::BITS_WIDE;
                end
                else
                begin
                    packet.shift_word = packet.shift_word | (word << (js * 15 + 1));
                    packet.bits_left = packet.bits_left + gsp_pkg::BITS_NARROW;
                end
            end
        end
    end

endmodule

// ----- sv/gsp_engine.sv -----
module gsp_engine (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  logic [gsp_pkg::OP_W-1:0] op,
    input  logic [gsp_pkg::PADS_W-1:0] pads,
    input  gsp_pkg::cfg_t cfg,
    input  gsp_pkg::packet_t data_packet,
    output logic wide_pending,
    output gsp_pkg::result_t result
);

    logic clock_level_reg, clock_level_next;
    logic [gsp_pkg::BITS_W-1:0] bits_left_reg, bits_left_next;
    logic [gsp_pkg::SHIFT_W-1:0] shift_word_reg, shift_word_next;
    logic wide_active_reg, wide_active_next;
    logic next_wide_reg, next_wide_next;
    logic poll_armed_reg, poll_armed_next;
    logic [gsp_pkg::COUNT_W-1:0] countdown_reg, countdown_next;
    logic trig_armed_reg, trig_armed_next;
    logic [gsp_pkg::TRIG_W-1:0] trig_left_reg, trig_left_next;
    logic [gsp_pkg::TRIG_W-1:0] window_left;

    assign wide_pending = next_wide_reg;
    assign window_left = trig_armed_reg ? trig_left_reg : '0;

    always_comb
    begin
        clock_level_next = clock_level_reg;
        bits_left_next = bits_left_reg;
        shift_word_next = shift_word_reg;
        wide_active_next = wide_active_reg;
        next_wide_next = next_wide_reg;
        poll_armed_next = poll_armed_reg;
        countdown_next = countdown_reg;
        trig_armed_next = trig_armed_reg;
        trig_left_next = trig_left_reg;

        unique case (op)
            gsp_pkg::OP_TICK:
            begin
                if (poll_armed_reg)
                begin
                    if (countdown_reg <= 10'd1)
                    begin
                        clock_level_next = !clock_level_reg;
                        if (clock_level_next)
                        begin
                            shift_word_next = wide_active_reg ? (shift_word_reg >> 3)
                                                              : (shift_word_reg >> 1);
                            if (bits_left_reg != '0)
                            begin
                                bits_left_next = bits_left_reg - 6'd1;
                            end
                        end
                        if (bits_left_next == 6'd1 && !clock_level_next)
                        begin
                            countdown_next = cfg.tail_delay;
                        end
                        else if (bits_left_next != '0)
                        begin
                            countdown_next = {2'b00, cfg.half_period};
                        end
                        else
                        begin
                            poll_armed_next = 1'b0;
                            countdown_next = '0;
                        end
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 10'd1;
                    end
                end
                if (trig_armed_reg)
                begin
                    if (trig_left_reg <= 14'd1)
                    begin
                        trig_armed_next = 1'b0;
                        trig_left_next = '0;
                    end
                    else
                    begin
                        trig_left_next = trig_left_reg - 14'd1;
                    end
                end
            end
            gsp_pkg::OP_WRITE:
            begin
                if (pads != '0)
                begin
                    if (bits_left_reg == '0)
                    begin
                        clock_level_next = 1'b1;
                        poll_armed_next = 1'b1;
                        countdown_next = {2'b00, cfg.start_delay};
                        if (window_left > cfg.id_window_low
                            && window_left < cfg.id_window_high)
                        begin
                            wide_active_next = 1'b0;
                            bits_left_next = gsp_pkg::ID_BITS;
                            shift_word_next = gsp_pkg::ID_WORD;
                        end
                        else
                        begin
                            wide_active_next = next_wide_reg;
                            next_wide_next = !next_wide_reg;
                            bits_left_next = data_packet.bits_left;
                            shift_word_next = data_packet.shift_word;
                        end
                    end
                    trig_armed_next = 1'b0;
                    trig_left_next = '0;
                end
            end
            gsp_pkg::OP_TIMEOUT:
            begin
                trig_armed_next = 1'b1;
                trig_left_next = (cfg.trigger_span == '0) ? 14'd1 : cfg.trigger_span;
            end
            default:
            begin
                trig_armed_next = trig_armed_reg;
            end
        endcase
    end

    always_comb
    begin
        logic [7:0] v;
        v = gsp_pkg::PORT_IDLE;
        if (poll_armed_next)
        begin
            v = {3'b000, clock_level_next, 4'h0};
            if (wide_active_next)
            begin
                v[7:5] = shift_word_next[2:0];
            end
            else
            begin
                v = v | gsp_pkg::PORT_NARROW_HIGH;
                v[5] = shift_word_next[0];
                if (bits_left_next > 6'd31 && !bits_left_next[0])
                begin
                    v[7] = 1'b0;
                end
            end
        end
        result.port_byte = (pads == '0) ? gsp_pkg::PORT_NO_PAD : v;
        result.busy = poll_armed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_level_reg <= 1'b0;
            bits_left_reg <= '0;
            shift_word_reg <= '0;
            wide_active_reg <= 1'b0;
            next_wide_reg <= 1'b0;
            poll_armed_reg <= 1'b0;
            countdown_reg <= '0;
            trig_armed_reg <= 1'b0;
            trig_left_reg <= '0;
        end
        else if (step)
        begin
            clock_level_reg <= clock_level_next;
            bits_left_reg <= bits_left_next;
            shift_word_reg <= shift_word_next;
            wide_active_reg <= wide_active_next;
            next_wide_reg <= next_wide_next;
            poll_armed_reg <= poll_armed_next;
            countdown_reg <= countdown_next;
            trig_armed_reg <= trig_armed_next;
            trig_left_reg <= trig_left_next;
        end
    end

endmodule

// ----- sv/gamepad_serial_packet_port_core.sv -----
// Flow: an accepted beat is registered in the input register, then processed by the engine,
// and its result is registered in the result register and offered from there.
// Throughput: one beat per cycle while the output is not stalled; the input register and the
// result register let a new beat enter while a finished result still waits on a stalled output.
// Reset: asynchronous, active low; engine state and valid flags clear, config registers take defaults.
module gamepad_serial_packet_port_core #(
    parameter int MAX_PADS = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [4:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready,
    input  logic in_valid,
    output logic in_stall,
    input  logic [1:0] op,
    input  logic [2:0] pads_present,
    input  logic [13:0] pad0_controls,
    input  logic [13:0] pad1_controls,
    input  logic [13:0] pad2_controls,
    input  logic [13:0] pad3_controls,
    output logic out_valid,
    input  logic out_stall,
    output logic [7:0] port_byte,
    output logic transfer_busy
);

    gsp_pkg::cfg_t cfg;
    gsp_pkg::item_t item_reg;
    gsp_pkg::packet_t data_packet;
    gsp_pkg::result_t result;
    logic item_valid_reg, item_valid_next;
    logic out_valid_reg, out_valid_next;
    logic [7:0] port_byte_reg;
    logic busy_reg;
    logic advance;
    logic accept;
    logic wide_pending;
    logic [gsp_pkg::PADS_W-1:0] pads_eff;

    gsp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept = in_valid && !in_stall;
    assign pads_eff = (item_reg.pads > MAX_PADS[gsp_pkg::PADS_W-1:0])
                      ? MAX_PADS[gsp_pkg::PADS_W-1:0] : item_reg.pads;

    gsp_packet_builder #(
        .MAX_PADS (MAX_PADS)
    ) u_builder (
        .controls (item_reg.controls),
        .pads     (pads_eff),
        .wide     (wide_pending),
        .packet   (data_packet)
    );

    gsp_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .op           (item_reg.op),
        .pads         (pads_eff),
        .cfg          (cfg),
        .data_packet  (data_packet),
        .wide_pending (wide_pending),
        .result       (result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg && out_stall;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op <= op;
            item_reg.pads <= pads_present;
            item_reg.controls <= {pad3_controls, pad2_controls, pad1_controls, pad0_controls};
        end
        if (advance)
        begin
            port_byte_reg <= result.port_byte;
            busy_reg <= result.busy;
        end
    end

    assign out_valid = out_valid_reg;
    assign port_byte = port_byte_reg;
    assign transfer_busy = busy_reg;

endmodule

// ----- sv/gsp_checker.sv -----
module gsp_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic [7:0] port_byte,
    input logic transfer_busy
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(port_byte) && $stable(transfer_busy))
        else $error("stalled result beat changed");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the result register is empty");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> ##2 out_valid)
        else $error("accepted beat produced no result");

    a_idle_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !transfer_busy |-> port_byte == 8'hf0 || port_byte == 8'hff)
        else $error("idle port read shows an unexpected value");

endmodule

bind gamepad_serial_packet_port_core gsp_checker u_gsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .port_byte     (port_byte),
    .transfer_busy (transfer_busy)
);
